>>> rtl/vlms_pkg.sv
// Shared types and codes for the volume local maximum scan.
// No dependencies.
package vlms_pkg;

  localparam logic KIND_CAND  = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  localparam logic [2:0] REG_WIN_X = 3'd0;
  localparam logic [2:0] REG_WIN_Y = 3'd1;
  localparam logic [2:0] REG_WIN_Z = 3'd2;
  localparam logic [2:0] REG_ORG_X = 3'd3;
  localparam logic [2:0] REG_ORG_Y = 3'd4;
  localparam logic [2:0] REG_ORG_Z = 3'd5;

  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [9:0]  pos_z;
    logic [15:0] center_value;
    logic [39:0] value_sum;
    logic [24:0] nonzero_count;
    logic [15:0] peak_value;
    logic        last;
  } out_item_t;

endpackage

>>> rtl/vlms_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vlms_ram #(
  parameter int W = 16,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/volume_local_max_scan_top.sv
// An accepted voxel passes the stage 1 register and the stage 2 window register
// before its result reaches the output register. Throughput: one voxel per cycle
// while the output is not stalled; a voxel that yields a candidate and the stats
// item holds the pipe while the stats item waits. Reset (rst_n, synchronous): scan
// position, stats and valid flags clear; the plane and row stores are not cleared,
// and stale entries in them feed no result. Depends on vlms_pkg and vlms_ram.
module volume_local_max_scan_top
  import vlms_pkg::*;
#(
  parameter int MAX_DIM    = 256,
  parameter int VOXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_voxel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [9:0]  out_pos_x,
  output logic [9:0]  out_pos_y,
  output logic [9:0]  out_pos_z,
  output logic [15:0] out_center_value,
  output logic [39:0] out_value_sum,
  output logic [24:0] out_nonzero_count,
  output logic [15:0] out_peak_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int VW = (VOXEL_BITS < 16) ? VOXEL_BITS : 16;
  localparam logic [11:0] MAXD = 12'(MAX_DIM);

  // configuration
  logic [8:0] win_x_r, win_y_r, win_z_r;
  logic [9:0] org_x_r, org_y_r, org_z_r;
  logic       cfg_wr;
  logic       cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_index inside {REG_WIN_X, REG_WIN_Y, REG_WIN_Z,
                                       REG_ORG_X, REG_ORG_Y, REG_ORG_Z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_r <= 9'd256;
      win_y_r <= 9'd256;
      win_z_r <= 9'd256;
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WIN_X: win_x_r <= cfg_data[8:0];
        REG_WIN_Y: win_y_r <= cfg_data[8:0];
        REG_WIN_Z: win_z_r <= cfg_data[8:0];
        REG_ORG_X: org_x_r <= cfg_data;
        REG_ORG_Y: org_y_r <= cfg_data;
        REG_ORG_Z: org_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped window size minus one
  logic [11:0] wx_c, wy_c, wz_c;
  logic [CW-1:0] wxm1, wym1, wzm1;

  always_comb begin
    wx_c = {3'b0, win_x_r};
    wy_c = {3'b0, win_y_r};
    wz_c = {3'b0, win_z_r};
    if (wx_c < 12'd3) wx_c = 12'd3;
    if (wy_c < 12'd3) wy_c = 12'd3;
    if (wz_c < 12'd3) wz_c = 12'd3;
    if (wx_c > MAXD) wx_c = MAXD;
    if (wy_c > MAXD) wy_c = MAXD;
    if (wz_c > MAXD) wz_c = MAXD;
  end

  assign wxm1 = CW'(wx_c - 12'd1);
  assign wym1 = CW'(wy_c - 12'd1);
  assign wzm1 = CW'(wz_c - 12'd1);

  // pipeline control
  logic adv;
  logic in_acc;
  logic s1_v_r, s2_v_r;
  logic o_v_r, p_v_r;
  logic o_free;

  assign o_free   = !o_v_r || out_ready;
  assign adv      = !s2_v_r || (o_free && !p_v_r);
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;

  // scan counters
  logic [CW-1:0] x_r, y_r, z_r;
  logic          at_end;

  assign at_end = (x_r == wxm1) && (y_r == wym1) && (z_r == wzm1);

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_wr && cfg_hit)) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else if (in_acc) begin
      if (at_end) begin
        x_r <= '0;
        y_r <= '0;
        z_r <= '0;
      end else if (x_r == wxm1) begin
        x_r <= '0;
        if (y_r == wym1) begin
          y_r <= '0;
          z_r <= z_r + 1'b1;
        end else begin
          y_r <= y_r + 1'b1;
        end
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // stage 1: voxel register, store reads land here
  logic [VW-1:0] s1_val_r;
  logic [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic          s1_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val_r <= in_voxel_value[VW-1:0];
      s1_x_r   <= x_r;
      s1_y_r   <= y_r;
      s1_z_r   <= z_r;
      s1_end_r <= at_end;
    end
  end

  // plane store: two older planes per (y,x); row store: two older towers per x
  logic [2*VW-1:0] pl_rd, pl_wr;
  logic [6*VW-1:0] row_rd, row_wr;
  logic            s1_mv;
  logic [VW-1:0]   tw [3];

  assign s1_mv = adv && s1_v_r;

  assign tw[0]  = pl_rd[VW-1:0];
  assign tw[1]  = pl_rd[2*VW-1:VW];
  assign tw[2]  = s1_val_r;
  assign pl_wr  = {s1_val_r, tw[1]};
  assign row_wr = {tw[2], tw[1], tw[0], row_rd[6*VW-1:3*VW]};

  vlms_ram #(.W(2*VW), .D(1 << (2*CW))) u_plane (
    .clk   (clk),
    .we    (s1_mv),
    .waddr ({s1_y_r, s1_x_r}),
    .wdata (pl_wr),
    .re    (in_acc),
    .raddr ({y_r, x_r}),
    .rdata (pl_rd)
  );

  vlms_ram #(.W(6*VW), .D(1 << CW)) u_row (
    .clk   (clk),
    .we    (s1_mv),
    .waddr (s1_x_r),
    .wdata (row_wr),
    .re    (in_acc),
    .raddr (x_r),
    .rdata (row_rd)
  );

  // stage 2: 3x3x3 window, indexed [x][y][z], oldest first
  logic [VW-1:0] w_r [3][3][3];
  logic          s2_int_r, s2_end_r;
  logic [9:0]    s2_px_r, s2_py_r, s2_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      for (int k = 0; k < 3; k++) begin
        w_r[2][0][k] <= row_rd[k*VW +: VW];
        w_r[2][1][k] <= row_rd[(3+k)*VW +: VW];
        w_r[2][2][k] <= tw[k];
      end
      s2_int_r <= (s1_x_r >= CW'(2)) && (s1_y_r >= CW'(2)) && (s1_z_r >= CW'(2));
      s2_end_r <= s1_end_r;
      s2_px_r  <= org_x_r + 10'(CW'(s1_x_r - 1'b1));
      s2_py_r  <= org_y_r + 10'(CW'(s1_y_r - 1'b1));
      s2_pz_r  <= org_z_r + 10'(CW'(s1_z_r - 1'b1));
    end
  end

  // compare center against its neighbors
  logic [VW-1:0] ctr;
  logic          is_max, cand;

  assign ctr = w_r[1][1][1];

  always_comb begin
    is_max = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          if (w_r[i][j][k] > ctr) is_max = 1'b0;
        end
      end
    end
  end

  assign cand = s2_int_r && is_max;

  // running stats
  logic [39:0] sum_r, sum_nxt;
  logic [24:0] cnt_r, cnt_nxt;
  logic [15:0] peak_r, peak_nxt;
  logic [40:0] sum_wide;
  logic        s2_mv;

  assign s2_mv    = adv && s2_v_r;
  assign sum_wide = {1'b0, sum_r} + 41'(ctr);

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    peak_nxt = peak_r;
    if (s2_int_r && (ctr != '0)) begin
      sum_nxt = sum_wide[40] ? SUM_MAX : sum_wide[39:0];
      if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
    end
    if (cand && (16'(ctr) > peak_r)) peak_nxt = 16'(ctr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_wr && cfg_hit)) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      peak_r <= '0;
    end else if (s2_mv) begin
      if (s2_end_r) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        peak_r <= '0;
      end else begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        peak_r <= peak_nxt;
      end
    end
  end

  // output register plus one pending stats item
  out_item_t cand_item, stats_item, o_r, p_r;

  always_comb begin
    cand_item              = '0;
    cand_item.kind         = KIND_CAND;
    cand_item.pos_x        = s2_px_r;
    cand_item.pos_y        = s2_py_r;
    cand_item.pos_z        = s2_pz_r;
    cand_item.center_value = 16'(ctr);
    stats_item               = '0;
    stats_item.kind          = KIND_STATS;
    stats_item.value_sum     = sum_nxt;
    stats_item.nonzero_count = cnt_nxt;
    stats_item.peak_value    = peak_nxt;
    stats_item.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else if (o_free) begin
      if (p_v_r) begin
        o_v_r <= 1'b1;
        p_v_r <= 1'b0;
      end else if (s2_v_r && (cand || s2_end_r)) begin
        o_v_r <= 1'b1;
        p_v_r <= cand && s2_end_r;
      end else begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      if (p_v_r) begin
        o_r <= p_r;
      end else begin
        o_r <= cand ? cand_item : stats_item;
        p_r <= stats_item;
      end
    end
  end

  assign out_valid         = o_v_r;
  assign out_kind          = o_r.kind;
  assign out_pos_x         = o_r.pos_x;
  assign out_pos_y         = o_r.pos_y;
  assign out_pos_z         = o_r.pos_z;
  assign out_center_value  = o_r.center_value;
  assign out_value_sum     = o_r.value_sum;
  assign out_nonzero_count = o_r.nonzero_count;
  assign out_peak_value    = o_r.peak_value;
  assign out_last          = o_r.last;

`ifndef SYNTH
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> o_v_r) else $error("pending stats item without output item");

  a_stats_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_STATS)) |-> out_last)
    else $error("stats item without last");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s2_v_r && o_v_r))
    else $error("input stalled with no item ahead");

  a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (p_v_r && out_ready) |=> !p_v_r) else $error("pending stats item not moved up");
`endif

endmodule
